>>> hdl/pulse_beat_detector_assert.svh
// assertion macros for the pulse beat detector checker
// depends on nothing; included by the checker file
`ifndef PULSE_BEAT_DETECTOR_ASSERT_SVH
`define PULSE_BEAT_DETECTOR_ASSERT_SVH
// implication checked every clock outside reset
`define PBD_ASSERT_IMP(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
// next-cycle implication checked outside reset
`define PBD_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`endif

>>> hdl/pbd_pkg.sv
// package for the pulse beat detector: phase codes, widths, constants
// no dependencies
`timescale 1ns / 1ps
package pbd_pkg;
  localparam int SmpW = 24;
  localparam int ThrW = 23;
  localparam int PerW = 30;
  localparam int RateW = 24;
  localparam int FacW = 16;
  localparam logic [2:0] PH_INIT   = 3'd0;
  localparam logic [2:0] PH_WAIT   = 3'd1;
  localparam logic [2:0] PH_FOLLOW = 3'd2;
  localparam logic [2:0] PH_MAYBE  = 3'd3;
  localparam logic [2:0] PH_MASK   = 3'd4;
  localparam logic [2:0] CFG_MIN_THR  = 3'd0;
  localparam logic [2:0] CFG_MAX_THR  = 3'd1;
  localparam logic [2:0] CFG_STEP     = 3'd2;
  localparam logic [2:0] CFG_DECAY    = 3'd3;
  localparam logic [2:0] CFG_FALLOFF  = 3'd4;
  localparam logic [2:0] CFG_ALPHA    = 3'd5;
  localparam logic [2:0] CFG_LOST     = 3'd6;
  localparam logic [2:0] CFG_MASK     = 3'd7;
  // 60000 * 65536 for the rate
  localparam logic [31:0] RATE_NUM = 32'd3932160000;
  localparam logic [PerW-1:0] PER_MAX = {PerW{1'b1}};
  localparam logic [RateW-1:0] RATE_MAX = {RateW{1'b1}};
endpackage

>>> hdl/pulse_beat_detector.sv
// pulse beat detector top level: phase machine plus shared sequential divider
// depends on pbd_pkg
`timescale 1ns / 1ps
// One filtered pulse sample word (signed Q16.8 plus ms timestamp) enters when
// in_valid is high and in_stall low; one result word (beat flag, threshold,
// smoothed period, rate) leaves on the out channel. A five-phase detector
// (init holdoff, waiting, following, maybe, masking) tracks an adaptive
// threshold. The block holds one word at a time: no new sample is accepted
// until the result has left, and any wait on out_stall delays that. The rate
// divide is skipped while the period is zero; the proportional decay divide
// can run as well in the waiting and masking phases when a peak and a period
// are known. The shared restoring divider produces one quotient bit per cycle
// (50 bits for the decay, 32 for the rate). Products go through one shared
// 40x24 multiplier, one per cycle, and are used combinationally in that cycle.
// Configuration is written through cfg_we, cfg_index and cfg_data, only while
// the block is idle: the user must keep to this, the block does not enforce it.
module pulse_beat_detector #(
  parameter int INIT_HOLDOFF_MS = 2000,
  parameter int SAMPLE_PERIOD_MS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [22:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [23:0] sample,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        beat,
  output logic [22:0] threshold_now,
  output logic [29:0] period_avg,
  output logic [23:0] rate_bpm
);
  // sequencer steps
  localparam logic [3:0] S_IDLE = 4'd0, S_EVAL = 4'd1, S_MUL1 = 4'd2, S_MUL2 = 4'd3,
    S_DECDIV = 4'd4, S_DECFIN = 4'd5, S_PERM1 = 4'd6, S_PERM2 = 4'd7, S_PERFIN = 4'd8,
    S_RATE = 4'd9, S_RDIV = 4'd10, S_OUT = 4'd11, S_GEOM = 4'd12;

  // configuration registers
  logic [22:0] min_threshold, max_threshold, step_margin;
  logic [15:0] decay_factor, falloff_target, period_alpha, lost_delay_ms, mask_holdoff_ms;

  // detector state
  logic [2:0]  phase;
  logic [22:0] threshold_reg;
  logic [29:0] beat_period_reg;
  logic signed [23:0] last_peak;
  logic [31:0] last_beat_time;

  // sequencer and datapath registers
  logic [3:0]  step;
  logic signed [23:0] smp;
  logic [31:0] now_r, gap;
  logic        beat_r;
  logic [63:0] acc;       // product / accumulator
  logic [63:0] dividend;  // shifting dividend, quotient grows in low bits
  logic [38:0] rem;
  logic [37:0] divisor;
  logic [5:0]  bit_cnt;

  // shared multiplier: one product per cycle, operands chosen by step
  logic [39:0] mul_a;
  logic [23:0] mul_b;
  logic [63:0] mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step)
      S_MUL1: begin
        mul_a = {17'd0, last_peak[22:0]};
        mul_b = {7'd0, 17'(18'h10000 - {2'b0, falloff_target})};
      end
      S_MUL2: begin
        mul_a = acc[39:0];
        mul_b = 24'(SAMPLE_PERIOD_MS);
      end
      S_GEOM: begin
        mul_a = {17'd0, threshold_reg};
        mul_b = {8'd0, decay_factor};
      end
      S_PERM1: begin
        mul_a = {gap, 8'd0};
        mul_b = {8'd0, period_alpha};
      end
      S_PERM2: begin
        mul_a = {10'd0, beat_period_reg};
        mul_b = {7'd0, 17'(18'h10000 - {2'b0, period_alpha})};
      end
      default: ;
    endcase
    mul_p = 64'(mul_a) * 64'(mul_b);
  end

  // one restoring divide step
  logic [38:0] rem_sh;
  logic        rem_ge;
  always_comb begin
    rem_sh = {rem[37:0], dividend[63]};
    rem_ge = rem_sh >= {1'b0, divisor};
  end

  logic signed [24:0] s_ext, thr_ext, max_ext;
  logic signed [25:0] s_plus;
  always_comb begin
    s_ext = 25'(smp);
    thr_ext = {2'b0, threshold_reg};
    max_ext = {2'b0, max_threshold};
    s_plus = 26'(smp) + {3'b0, step_margin};
  end

  logic [64:0] per_sum;
  assign per_sum = {1'b0, acc} + {1'b0, mul_p} + 65'd32768;

  assign in_stall = (step != S_IDLE);
  assign out_valid = (step == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_threshold <= 23'd5120;
      max_threshold <= 23'd204800;
      step_margin <= 23'd7680;
      decay_factor <= 16'd64881;
      falloff_target <= 16'd19661;
      period_alpha <= 16'd39322;
      lost_delay_ms <= 16'd2000;
      mask_holdoff_ms <= 16'd200;
      phase <= pbd_pkg::PH_INIT;
      threshold_reg <= 23'd5120;
      beat_period_reg <= '0;
      last_peak <= '0;
      last_beat_time <= '0;
      step <= S_IDLE;
      beat_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pbd_pkg::CFG_MIN_THR: min_threshold <= cfg_data;
          pbd_pkg::CFG_MAX_THR: max_threshold <= cfg_data;
          pbd_pkg::CFG_STEP:    step_margin <= cfg_data;
          pbd_pkg::CFG_DECAY:   decay_factor <= cfg_data[15:0];
          pbd_pkg::CFG_FALLOFF: falloff_target <= cfg_data[15:0];
          pbd_pkg::CFG_ALPHA:   period_alpha <= cfg_data[15:0];
          pbd_pkg::CFG_LOST:    lost_delay_ms <= cfg_data[15:0];
          pbd_pkg::CFG_MASK:    mask_holdoff_ms <= cfg_data[15:0];
          default: ;
        endcase
      end
      case (step)
        S_IDLE: begin
          if (in_valid) begin
            smp <= sample;
            now_r <= now_ms;
            gap <= now_ms - last_beat_time;
            beat_r <= 1'b0;
            step <= S_EVAL;
          end
        end
        S_EVAL: begin
          case (phase)
            pbd_pkg::PH_WAIT: begin
              if (s_ext > thr_ext) begin
                threshold_reg <= (s_ext < max_ext) ? smp[22:0] : max_threshold;
                phase <= pbd_pkg::PH_FOLLOW;
              end
              if ({16'd0, lost_delay_ms} < gap) begin
                beat_period_reg <= '0;
                last_peak <= '0;
                step <= S_GEOM;
              end else if (last_peak > 0 && beat_period_reg != '0) begin
                step <= S_MUL1;
              end else begin
                step <= S_GEOM;
              end
            end
            pbd_pkg::PH_FOLLOW: begin
              if (s_ext < thr_ext) phase <= pbd_pkg::PH_MAYBE;
              else threshold_reg <= (s_ext < max_ext) ? smp[22:0] : max_threshold;
              step <= S_RATE;
            end
            pbd_pkg::PH_MAYBE: begin
              if (s_plus < 26'(thr_ext)) begin
                beat_r <= 1'b1;
                last_peak <= smp;
                phase <= pbd_pkg::PH_MASK;
                last_beat_time <= now_r;
                step <= (gap != '0) ? S_PERM1 : S_RATE;
              end else begin
                phase <= pbd_pkg::PH_FOLLOW;
                step <= S_RATE;
              end
            end
            pbd_pkg::PH_MASK: begin
              if ({16'd0, mask_holdoff_ms} < gap) phase <= pbd_pkg::PH_WAIT;
              step <= (last_peak > 0 && beat_period_reg != '0) ? S_MUL1 : S_GEOM;
            end
            default: begin
              if (now_r > 32'(INIT_HOLDOFF_MS)) phase <= pbd_pkg::PH_WAIT;
              step <= S_RATE;
            end
          endcase
        end
        S_GEOM: begin
          // geometric decay then minimum clamp
          threshold_reg <= (mul_p[38:16] < min_threshold) ? min_threshold : mul_p[38:16];
          step <= S_RATE;
        end
        S_MUL1: begin
          acc <= mul_p;
          step <= S_MUL2;
        end
        S_MUL2: begin
          // numerator is at most 50 bits wide
          dividend <= {mul_p[49:0], 14'd0};
          rem <= '0;
          divisor <= {beat_period_reg, 8'd0};
          bit_cnt <= 6'd50;
          step <= S_DECDIV;
        end
        S_DECDIV: begin
          rem <= rem_ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
          dividend <= {dividend[62:0], rem_ge};
          bit_cnt <= bit_cnt - 6'd1;
          if (bit_cnt == 6'd1) step <= S_DECFIN;
        end
        S_DECFIN: begin
          if (dividend[49:0] >= {27'd0, threshold_reg}) threshold_reg <= min_threshold;
          else if ((threshold_reg - dividend[22:0]) < min_threshold)
            threshold_reg <= min_threshold;
          else threshold_reg <= threshold_reg - dividend[22:0];
          step <= S_RATE;
        end
        S_PERM1: begin
          acc <= mul_p;
          step <= S_PERM2;
        end
        S_PERM2: begin
          beat_period_reg <= (per_sum[64:16] > {19'd0, pbd_pkg::PER_MAX}) ?
            pbd_pkg::PER_MAX : per_sum[45:16];
          step <= S_RATE;
        end
        S_RATE: begin
          if (beat_period_reg == '0) begin
            rate_bpm <= '0;
            step <= S_OUT;
          end else begin
            dividend <= {pbd_pkg::RATE_NUM, 32'd0};
            rem <= '0;
            divisor <= {8'd0, beat_period_reg};
            bit_cnt <= 6'd32;
            step <= S_RDIV;
          end
        end
        S_RDIV: begin
          rem <= rem_ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
          dividend <= {dividend[62:0], rem_ge};
          bit_cnt <= bit_cnt - 6'd1;
          if (bit_cnt == 6'd1) begin
            step <= S_PERFIN;
          end
        end
        S_PERFIN: begin
          rate_bpm <= (dividend[31:24] != 8'd0) ? pbd_pkg::RATE_MAX : dividend[23:0];
          step <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) step <= S_IDLE;
        end
        default: step <= S_IDLE;
      endcase
    end
  end

  assign beat = beat_r;
  assign threshold_now = threshold_reg;
  assign period_avg = beat_period_reg;
endmodule

>>> hdl/pbd_checker.sv
// port-level checker for the pulse beat detector, bound to the top level
// depends on pulse_beat_detector_assert.svh
`timescale 1ns / 1ps
`include "pulse_beat_detector_assert.svh"
module pbd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        beat,
  input logic [22:0] threshold_now,
  input logic [29:0] period_avg,
  input logic [23:0] rate_bpm
);
  // a result word waiting holds its payload
  `PBD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(threshold_now) && $stable(rate_bpm), "stalled result changed")
  // one word at a time: a pending result blocks new input
  `PBD_ASSERT_IMP(a_busy, clk, rst, out_valid, in_stall, "input taken while result pending")
  // rate is zero whenever no period is known
  `PBD_ASSERT_IMP(a_rate0, clk, rst, out_valid && period_avg == 30'd0, rate_bpm == 24'd0, "rate without period")
  // an accepted word blocks input the next cycle
  `PBD_ASSERT_NEXT(a_accept, clk, rst, in_valid && !in_stall, in_stall, "not busy after accept")
endmodule

bind pulse_beat_detector pbd_checker u_pbd_checker (.*);
